// ===== rtl/obm_pkg.sv =====
// Shared types and constants for the order book matching unit.
package obm_pkg;

  localparam int MaxOrders  = 64;
  localparam int MaxResults = 64;
  localparam int SlotW      = $clog2(MaxOrders);
  localparam int CntW       = $clog2(MaxOrders + 1);
  localparam int TradeW     = $clog2(MaxResults);

  typedef enum logic [2:0] {
    ST_RESTED    = 3'd0,
    ST_FILLED    = 3'd1,
    ST_KILLED    = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_CANCELLED = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_CANCEL = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic KIND_FAK  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] order_id;
    logic        side;
    logic        order_kind;
    logic [31:0] price;
    logic [31:0] quantity;
  } cmd_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_SCAN,
    EX_DECIDE,
    EX_TRADE,
    EX_STATUS
  } ex_state_t;

  typedef struct packed {
    logic        is_trade;
    logic [2:0]  status;
    logic [31:0] buy_id;
    logic [31:0] buy_price;
    logic [31:0] sell_id;
    logic [31:0] sell_price;
    logic [31:0] fill_quantity;
    logic        last;
  } result_t;

endpackage

// ===== rtl/obm_cmd_fifo.sv =====
// Two-entry command queue between the input front and the matching engine.
module obm_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  obm_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_take,
  output obm_pkg::cmd_t rd_data
);
  import obm_pkg::*;

  cmd_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |=> !(cnt_r == 2'd0))
    else $error("queue count jumped from full to empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid && !pop |=> rd_valid)
    else $error("queue lost an entry");
`endif
endmodule

// ===== rtl/obm_engine.sv =====
// Matching engine: book storage, sequential scans and result generation.
module obm_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_take,
  input  obm_pkg::cmd_t    cmd,
  output logic             res_valid,
  input  logic             res_stall,
  output obm_pkg::result_t res
);
  import obm_pkg::*;

  logic [31:0] id_mem    [MaxOrders];
  logic [31:0] price_mem [MaxOrders];
  logic [31:0] rem_mem   [MaxOrders];
  logic [31:0] arr_mem   [MaxOrders];
  logic        side_mem  [MaxOrders];
  logic [MaxOrders-1:0] valid_r;

  ex_state_t   state_r, state_nxt;
  cmd_t        cmd_r;
  logic [31:0] arrival_r;
  logic [31:0] rem_r;
  logic [TradeW-1:0] ntrade_r;
  logic        first_r;
  logic [CntW-1:0] idx_r;
  logic        hit_r, kill_r, best_ok_r, free_ok_r;
  logic [SlotW-1:0] hit_slot_r, best_r, free_r;
  logic [31:0] best_price_r, best_age_r, best_id_r, best_rem_r;
  logic        cmp_v_r;
  logic [SlotW-1:0] cmp_idx_r;
  logic [31:0] rd_id_r, rd_price_r, rd_rem_r, rd_arr_r;
  logic        rd_side_r;
  logic        out_v_r;
  result_t     out_r, out_nxt;

  logic [SlotW-1:0] rd_addr;
  logic [31:0] s_age;
  logic        s_valid, s_free, s_hit, s_take, better;
  logic        scan_done, crosses, can_trade, kill_now;
  logic [31:0] m;
  logic        out_free, trade_go, status_go, rest_en;

  // one registered read per cycle: scan index while scanning, else the cancel hit
  assign rd_addr   = (state_r == EX_SCAN) ? idx_r[SlotW-1:0] : hit_slot_r;
  assign s_valid   = cmp_v_r && valid_r[cmp_idx_r];
  assign s_free    = cmp_v_r && !valid_r[cmp_idx_r];
  assign s_age     = arrival_r - rd_arr_r;
  assign s_hit     = s_valid && first_r && (rd_id_r == cmd_r.order_id);
  assign s_take    = s_valid && (rd_side_r != cmd_r.side) && better;

  always_comb begin
    if (!best_ok_r) begin
      better = 1'b1;
    end else if (cmd_r.side == SIDE_BUY) begin
      better = (rd_price_r < best_price_r) ||
               (rd_price_r == best_price_r && s_age > best_age_r);
    end else begin
      better = (rd_price_r > best_price_r) ||
               (rd_price_r == best_price_r && s_age > best_age_r);
    end
  end

  assign scan_done = (idx_r == CntW'(MaxOrders));
  assign crosses   = best_ok_r && ((cmd_r.side == SIDE_BUY) ?
                     (cmd_r.price >= best_price_r) : (cmd_r.price <= best_price_r));
  assign can_trade = crosses && (rem_r != 32'd0) && (ntrade_r != TradeW'(MaxResults - 1));
  assign kill_now  = first_r && (cmd_r.order_kind == KIND_FAK) && !crosses;
  assign m         = (rem_r < best_rem_r) ? rem_r : best_rem_r;
  assign out_free  = !out_v_r || !res_stall;
  assign trade_go  = (state_r == EX_TRADE) && out_free;
  assign status_go = (state_r == EX_STATUS) && out_free;
  assign rest_en   = status_go && cmd_r.opcode == OP_ADD && !hit_r && free_ok_r &&
                     rem_r != 32'd0 && cmd_r.order_kind != KIND_FAK;
  assign res_valid = out_v_r;
  assign res       = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EX_IDLE:   if (cmd_valid) state_nxt = EX_SCAN;
      EX_SCAN:   if (scan_done) state_nxt = EX_DECIDE;
      EX_DECIDE: begin
        if (cmd_r.opcode == OP_CANCEL || hit_r || kill_now || !free_ok_r || !can_trade) begin
          state_nxt = EX_STATUS;
        end else begin
          state_nxt = EX_TRADE;
        end
      end
      EX_TRADE:  if (out_free) state_nxt = EX_SCAN;
      EX_STATUS: if (out_free) state_nxt = EX_IDLE;
      default:   state_nxt = EX_IDLE;
    endcase
  end

  always_comb begin
    cmd_take              = (state_r == EX_IDLE) && cmd_valid;
    out_nxt               = '0;
    out_nxt.is_trade      = (state_r == EX_TRADE);
    out_nxt.last          = (state_r == EX_STATUS);
    out_nxt.fill_quantity = rem_r;
    if (state_r == EX_TRADE) begin
      out_nxt.fill_quantity = m;
      if (cmd_r.side == SIDE_BUY) begin
        out_nxt.buy_id     = cmd_r.order_id;
        out_nxt.buy_price  = cmd_r.price;
        out_nxt.sell_id    = best_id_r;
        out_nxt.sell_price = best_price_r;
      end else begin
        out_nxt.buy_id     = best_id_r;
        out_nxt.buy_price  = best_price_r;
        out_nxt.sell_id    = cmd_r.order_id;
        out_nxt.sell_price = cmd_r.price;
      end
    end else if (cmd_r.opcode == OP_CANCEL) begin
      out_nxt.status        = hit_r ? ST_CANCELLED : ST_NOT_FOUND;
      out_nxt.fill_quantity = hit_r ? rd_rem_r : 32'd0;
    end else if (hit_r) begin
      out_nxt.status = ST_DUPLICATE;
    end else if (kill_r) begin
      out_nxt.status = ST_KILLED;
    end else if (!free_ok_r) begin
      out_nxt.status = ST_FULL;
    end else if (rem_r == 32'd0) begin
      out_nxt.status = ST_FILLED;
    end else if (cmd_r.order_kind == KIND_FAK) begin
      out_nxt.status = ST_KILLED;
    end else begin
      out_nxt.status = ST_RESTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rest_en) begin
      id_mem[free_r]    <= cmd_r.order_id;
      price_mem[free_r] <= cmd_r.price;
      rem_mem[free_r]   <= rem_r;
      arr_mem[free_r]   <= arrival_r;
      side_mem[free_r]  <= cmd_r.side;
    end else if (trade_go) begin
      rem_mem[best_r] <= best_rem_r - m;
    end
    rd_id_r    <= id_mem[rd_addr];
    rd_price_r <= price_mem[rd_addr];
    rd_rem_r   <= rem_mem[rd_addr];
    rd_arr_r   <= arr_mem[rd_addr];
    rd_side_r  <= side_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cmd_r <= cmd;
    if (cmd_take) begin
      rem_r <= cmd.quantity;
    end else if (trade_go) begin
      rem_r <= rem_r - m;
    end
    if (s_take) begin
      best_r       <= cmp_idx_r;
      best_price_r <= rd_price_r;
      best_age_r   <= s_age;
      best_id_r    <= rd_id_r;
      best_rem_r   <= rd_rem_r;
    end
    if (s_hit && !hit_r) hit_slot_r <= cmp_idx_r;
    if (s_free && first_r && !free_ok_r) free_r <= cmp_idx_r;
    cmp_idx_r <= idx_r[SlotW-1:0];
    if (trade_go || status_go) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= EX_IDLE;
      valid_r   <= '0;
      arrival_r <= 32'd0;
      out_v_r   <= 1'b0;
      idx_r     <= '0;
      ntrade_r  <= '0;
      first_r   <= 1'b1;
      hit_r     <= 1'b0;
      kill_r    <= 1'b0;
      best_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
      cmp_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= trade_go || status_go || (out_v_r && res_stall);
      cmp_v_r <= (state_r == EX_SCAN) && !scan_done;
      idx_r   <= (state_r == EX_SCAN) ? idx_r + 1'b1 : '0;
      if (cmd_take) begin
        ntrade_r <= '0;
      end else if (trade_go) begin
        ntrade_r <= ntrade_r + 1'b1;
      end
      if (cmd_take) begin
        first_r <= 1'b1;
      end else if (state_r == EX_DECIDE) begin
        first_r <= 1'b0;
      end
      if (cmd_take) begin
        hit_r <= 1'b0;
      end else if (s_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd_take) begin
        kill_r <= 1'b0;
      end else if (state_r == EX_DECIDE && kill_now) begin
        kill_r <= 1'b1;
      end
      if (cmd_take || trade_go) begin
        best_ok_r <= 1'b0;
      end else if (s_take) begin
        best_ok_r <= 1'b1;
      end
      if (cmd_take) begin
        free_ok_r <= 1'b0;
      end else if (s_free && first_r) begin
        free_ok_r <= 1'b1;
      end
      if (trade_go && best_rem_r == m) begin
        valid_r[best_r] <= 1'b0;
      end else if (status_go && cmd_r.opcode == OP_CANCEL && hit_r) begin
        valid_r[hit_slot_r] <= 1'b0;
      end else if (rest_en) begin
        valid_r[free_r] <= 1'b1;
      end
      if (rest_en) arrival_r <= arrival_r + 32'd1;
    end
  end

`ifndef ASSERT_OFF
  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.is_trade |-> !out_r.last)
    else $error("trade record marked last");
  a_trade_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EX_TRADE |-> valid_r[best_r])
    else $error("trading against an empty slot");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> state_r == EX_SCAN)
    else $error("command taken outside idle");
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EX_STATUS && out_free |=> state_r == EX_IDLE && out_v_r && out_r.last)
    else $error("status record not issued");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_stall |=> out_v_r && $stable(out_r))
    else $error("stalled result changed");
`endif
endmodule

// ===== rtl/order_book_matching_unit.sv =====
// Top level of the order book matching unit.
// Limit order book with price-time priority over 64 slots. The engine takes
// a command from the queue, then scans the book (registered reads, one slot
// per cycle) and decides; each trade emitted is followed by another scan and
// decide to find the next best resting order. A two-entry queue lets inputs
// be taken while the engine works; the result register holds one record.
// Duplicate, full and fill-and-kill checks share the first scan.
module order_book_matching_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_order_id,
  input  logic        in_side,
  input  logic        in_order_kind,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_trade,
  output logic [2:0]  out_status,
  output logic [31:0] out_buy_id,
  output logic [31:0] out_buy_price,
  output logic [31:0] out_sell_id,
  output logic [31:0] out_sell_price,
  output logic [31:0] out_fill_quantity,
  output logic        out_last
);
  import obm_pkg::*;

  cmd_t    in_cmd, q_cmd;
  logic    q_valid, q_take;
  result_t res;

  always_comb begin
    in_cmd.opcode     = in_opcode;
    in_cmd.order_id   = in_order_id;
    in_cmd.side       = in_side;
    in_cmd.order_kind = in_order_kind;
    in_cmd.price      = in_price;
    in_cmd.quantity   = in_quantity;
  end

  obm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_stall (in_stall),
    .wr_data  (in_cmd),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_cmd)
  );

  obm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_take  (q_take),
    .cmd       (q_cmd),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign out_is_trade      = res.is_trade;
  assign out_status        = res.status;
  assign out_buy_id        = res.buy_id;
  assign out_buy_price     = res.buy_price;
  assign out_sell_id       = res.sell_id;
  assign out_sell_price    = res.sell_price;
  assign out_fill_quantity = res.fill_quantity;
  assign out_last          = res.last;
endmodule

// ===== test/tb_top.sv =====
// Testbench for the order book matching unit: directed table, then random checked traffic.
`timescale 1ns / 100ps

module tb_top;
  import obm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_ADD;
  logic [31:0] in_order_id = '0;
  logic        in_side = SIDE_BUY;
  logic        in_order_kind = 1'b0;
  logic [31:0] in_price = '0;
  logic [31:0] in_quantity = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_trade;
  logic [2:0]  out_status;
  logic [31:0] out_buy_id;
  logic [31:0] out_buy_price;
  logic [31:0] out_sell_id;
  logic [31:0] out_sell_price;
  logic [31:0] out_fill_quantity;
  logic        out_last;

  localparam logic SIDE_SELL = 1'b1;
  localparam logic KIND_GTC  = 1'b0;

  order_book_matching_unit dut (.*);

  typedef struct {
    cmd_t        c;
    bit          typed;
    status_t     st;
    logic [31:0] q;
  } row_t;

  // book image
  bit          bk_valid[MaxOrders];
  logic [31:0] bk_id[MaxOrders];
  logic        bk_side[MaxOrders];
  logic [31:0] bk_price[MaxOrders];
  logic [31:0] bk_rem[MaxOrders];
  logic [31:0] bk_arr[MaxOrders];
  logic [31:0] arr_cnt = '0;

  result_t     expected_q[$];
  result_t     staged_q[$];
  int          errors = 0;
  int          n_items = 0;
  int          n_trades = 0;
  int          n_status = 0;
  int          tx_pct = 17;
  int          rx_pct = 81;
  row_t        dir_tab[$];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < MaxOrders; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < MaxOrders; i++)
      if (!bk_valid[i]) return i;
    return -1;
  endfunction

  function automatic int best_opposite(logic side);
    int best;
    logic opp;
    best = -1;
    opp = ~side;
    for (int i = 0; i < MaxOrders; i++) begin
      if (!bk_valid[i] || bk_side[i] != opp) continue;
      if (best < 0) best = i;
      else if (opp == SIDE_SELL ? bk_price[i] < bk_price[best] : bk_price[i] > bk_price[best])
        best = i;
      else if (bk_price[i] == bk_price[best] &&
               (arr_cnt - bk_arr[i]) > (arr_cnt - bk_arr[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic bit crosses(logic side, logic [31:0] price, int idx);
    return side == SIDE_BUY ? price >= bk_price[idx] : price <= bk_price[idx];
  endfunction

  function automatic result_t status_rec(status_t st, logic [31:0] q);
    result_t r;
    r = '0;
    r.status = st;
    r.fill_quantity = q;
    r.last = 1'b1;
    return r;
  endfunction

  // Applies one command to the book image, queueing the records it causes into staged_q.
  task automatic book_apply(cmd_t c);
    int b, fs, n;
    logic [31:0] rem, m;
    result_t t;
    status_t st;
    n = 0;
    if (c.opcode == OP_CANCEL) begin
      b = find_order(c.order_id);
      if (b >= 0) begin
        bk_valid[b] = 1'b0;
        staged_q = {staged_q, status_rec(ST_CANCELLED, bk_rem[b])};
      end else staged_q = {staged_q, status_rec(ST_NOT_FOUND, '0)};
      return;
    end
    if (find_order(c.order_id) >= 0) begin
      staged_q = {staged_q, status_rec(ST_DUPLICATE, c.quantity)};
      return;
    end
    if (c.order_kind == KIND_FAK) begin
      b = best_opposite(c.side);
      if (b < 0 || !crosses(c.side, c.price, b)) begin
        staged_q = {staged_q, status_rec(ST_KILLED, c.quantity)};
        return;
      end
    end
    fs = find_free();
    if (fs < 0) begin
      staged_q = {staged_q, status_rec(ST_FULL, c.quantity)};
      return;
    end
    rem = c.quantity;
    while (rem != 0 && n < MaxResults - 1) begin
      b = best_opposite(c.side);
      if (b < 0 || !crosses(c.side, c.price, b)) break;
      m = rem < bk_rem[b] ? rem : bk_rem[b];
      t = '0;
      t.is_trade = 1'b1;
      t.fill_quantity = m;
      if (c.side == SIDE_BUY) begin
        t.buy_id = c.order_id; t.buy_price = c.price;
        t.sell_id = bk_id[b];  t.sell_price = bk_price[b];
      end else begin
        t.buy_id = bk_id[b];    t.buy_price = bk_price[b];
        t.sell_id = c.order_id; t.sell_price = c.price;
      end
      staged_q = {staged_q, t};
      n++;
      rem -= m;
      bk_rem[b] -= m;
      if (bk_rem[b] == 0) bk_valid[b] = 1'b0;
    end
    if (rem == 0) st = ST_FILLED;
    else if (c.order_kind == KIND_FAK) st = ST_KILLED;
    else begin
      bk_valid[fs] = 1'b1;
      bk_id[fs] = c.order_id;
      bk_side[fs] = c.side;
      bk_price[fs] = c.price;
      bk_rem[fs] = rem;
      bk_arr[fs] = arr_cnt;
      arr_cnt++;
      st = ST_RESTED;
    end
    staged_q = {staged_q, status_rec(st, rem)};
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] exp);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (record %0d)", what, got, exp,
             n_trades + n_status);
  endtask

  // Drives one command and waits for its transfer; typed rows override the predicted records.
  task automatic send(cmd_t c, bit typed = 1'b0, status_t st = ST_RESTED,
                      logic [31:0] q = '0);
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_pct);
    end
    in_valid      <= 1'b1;
    in_opcode     <= c.opcode;
    in_order_id   <= c.order_id;
    in_side       <= c.side;
    in_order_kind <= c.order_kind;
    in_price      <= c.price;
    in_quantity   <= c.quantity;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    staged_q.delete();
    book_apply(c);
    if (typed) begin
      staged_q.delete();
      staged_q = {staged_q, status_rec(st, q)};
    end
    expected_q = {expected_q, staged_q};
  endtask

  function automatic cmd_t mk(logic op, logic [31:0] id, logic side, logic kind,
                              logic [31:0] price, logic [31:0] qty);
    cmd_t c;
    c.opcode = op; c.order_id = id; c.side = side;
    c.order_kind = kind; c.price = price; c.quantity = qty;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.opcode     = ($urandom_range(99) < 20) ? OP_CANCEL : OP_ADD;
    c.order_id   = ($urandom_range(99) < 85) ? $urandom_range(0, 40) : $urandom;
    c.side       = 1'($urandom_range(1));
    c.order_kind = ($urandom_range(99) < 25) ? KIND_FAK : KIND_GTC;
    c.price      = ($urandom_range(99) < 88) ? 32'd1000 + $urandom_range(0, 16) : $urandom;
    case ($urandom_range(9))
      0:       c.quantity = '0;
      1, 2:    c.quantity = $urandom;
      default: c.quantity = $urandom_range(1, 20);
    endcase
    return c;
  endfunction

  function automatic void add_row(cmd_t c, bit typed = 1'b0, status_t st = ST_RESTED,
                                  logic [31:0] q = '0);
    row_t r;
    r.c = c; r.typed = typed; r.st = st; r.q = q;
    dir_tab = {dir_tab, r};
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (out_is_trade) n_trades++; else n_status++;
      if (expected_q.size() == 0) begin
        report("unexpected record, buy_id", out_buy_id, 32'd0);
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (out_is_trade !== e.is_trade)
          report("is_trade", 32'(out_is_trade), 32'(e.is_trade));
        if (out_status !== e.status) report("status", 32'(out_status), 32'(e.status));
        if (out_buy_id !== e.buy_id) report("buy_id", out_buy_id, e.buy_id);
        if (out_buy_price !== e.buy_price) report("buy_price", out_buy_price, e.buy_price);
        if (out_sell_id !== e.sell_id) report("sell_id", out_sell_id, e.sell_id);
        if (out_sell_price !== e.sell_price)
          report("sell_price", out_sell_price, e.sell_price);
        if (out_fill_quantity !== e.fill_quantity)
          report("fill_quantity", out_fill_quantity, e.fill_quantity);
        if (out_last !== e.last) report("last", 32'(out_last), 32'(e.last));
      end
    end
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  initial begin
    logic [31:0] resting[$];
    for (int i = 0; i < MaxOrders; i++) bk_valid[i] = 1'b0;

    add_row(mk(OP_CANCEL, 5, SIDE_BUY, KIND_GTC, 0, 0), 1'b1, ST_NOT_FOUND, 0);
    add_row(mk(OP_ADD, 1, SIDE_BUY, KIND_GTC, 100, 10), 1'b1, ST_RESTED, 10);
    add_row(mk(OP_ADD, 2, SIDE_SELL, KIND_FAK, 200, 7), 1'b1, ST_KILLED, 7);
    add_row(mk(OP_ADD, 1, SIDE_SELL, KIND_GTC, 50, 3), 1'b1, ST_DUPLICATE, 3);
    add_row(mk(OP_ADD, 6, SIDE_BUY, KIND_GTC, 100, 5));
    add_row(mk(OP_ADD, 3, SIDE_SELL, KIND_GTC, 90, 12));
    add_row(mk(OP_ADD, 4, SIDE_BUY, KIND_GTC, 100, 0), 1'b1, ST_FILLED, 0);
    add_row(mk(OP_ADD, 7, SIDE_SELL, KIND_FAK, 0, 2));
    add_row(mk(OP_ADD, 0, SIDE_BUY, KIND_GTC, '1, '1));
    add_row(mk(OP_ADD, '1, SIDE_SELL, KIND_GTC, 0, '1));
    add_row(mk(OP_ADD, 8, SIDE_SELL, KIND_GTC, '1, 1));
    add_row(mk(OP_ADD, 9, SIDE_BUY, KIND_FAK, 5, 4));
    add_row(mk(OP_CANCEL, 8, SIDE_SELL, KIND_FAK, '1, '1));
    add_row(mk(OP_CANCEL, 8, SIDE_BUY, KIND_GTC, 0, 0), 1'b1, ST_NOT_FOUND, 0);
    add_row(mk(OP_CANCEL, 3, SIDE_SELL, KIND_FAK, '1, '1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].st, dir_tab[i].q);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);

    repeat (150) send(rand_cmd());

    // empty the book, fill it, overflow it, then sweep it
    tx_pct = 81; rx_pct = 17;
    for (int i = 0; i < MaxOrders; i++) if (bk_valid[i]) resting = {resting, bk_id[i]};
    foreach (resting[i])
      send(mk(OP_CANCEL, resting[i], 1'($urandom_range(1)), KIND_GTC, $urandom, 1));
    for (int k = 0; k < MaxOrders; k++)
      send(mk(OP_ADD, 5000 + k, SIDE_BUY, KIND_GTC, 10 + k % 5, $urandom_range(1, 3)));
    send(mk(OP_ADD, 7000, SIDE_SELL, KIND_GTC, 500, 2), 1'b1, ST_FULL, 2);
    send(mk(OP_CANCEL, 5000, SIDE_BUY, KIND_GTC, 0, 0));
    send(mk(OP_ADD, 9000, SIDE_SELL, KIND_GTC, 0, '1));
    send(mk(OP_CANCEL, 9000, SIDE_BUY, KIND_GTC, 0, 0));

    tx_pct = 0; rx_pct = 0;
    repeat (150) send(rand_cmd());
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d commands: %0d trades and %0d status records, incl. full book",
             n_items, n_trades, n_status);
    $display("and a 63-trade sweep, under three sender/receiver stall mixes.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
